/* sv/erv_pkg.sv */
// Shared constants, types and the quarter-wave sine table for the vertex rotator.
`default_nettype none

package erv_pkg;

  localparam int TRIG_FRAC = 30;
  localparam int TRIG_W = 32;
  localparam int SIN_IDX_W = 7;
  localparam int SIN_ENTRIES = 91;
  localparam int ANGLE_W = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_Z = 2'd2;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic [SIN_ENTRIES-1:0][TRIG_FRAC:0] sin_table_t;

  // Sine of d whole degrees in unsigned Q1.30, Taylor series to the x^17 term.
  function automatic logic [TRIG_FRAC:0] sine_rom(input int unsigned d);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum = x;
    term = ((term * x2 + (64'd1 << 29)) >> 30) / 64'd6;
    sum = sum - term;
    term = ((term * x2 + (64'd1 << 29)) >> 30) / 64'd20;
    sum = sum + term;
    term = ((term * x2 + (64'd1 << 29)) >> 30) / 64'd42;
    sum = sum - term;
    term = ((term * x2 + (64'd1 << 29)) >> 30) / 64'd72;
    sum = sum + term;
    term = ((term * x2 + (64'd1 << 29)) >> 30) / 64'd110;
    sum = sum - term;
    term = ((term * x2 + (64'd1 << 29)) >> 30) / 64'd156;
    sum = sum + term;
    term = ((term * x2 + (64'd1 << 29)) >> 30) / 64'd210;
    sum = sum - term;
    term = ((term * x2 + (64'd1 << 29)) >> 30) / 64'd272;
    sum = sum + term;
    if (sum > (64'd1 << TRIG_FRAC)) begin
      sum = 64'd1 << TRIG_FRAC;
    end
    return sum[TRIG_FRAC:0];
  endfunction

  function automatic sin_table_t build_sin_table();
    sin_table_t t;
    for (int d = 0; d < SIN_ENTRIES; d++) begin
      t[d] = sine_rom(d);
    end
    return t;
  endfunction

  localparam sin_table_t SIN_TABLE = build_sin_table();

endpackage

`default_nettype wire

/* sv/erv_matrix.sv */
// Angle registers and the sequenced rotation matrix builder with one shared multiplier.
`default_nettype none

module erv_matrix #(
  parameter int COEF_FRAC_BITS = 16,
  localparam int COEF_W = COEF_FRAC_BITS + 2
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_we,
  input  wire  [erv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [erv_pkg::ANGLE_W-1:0]       cfg_data,
  output logic signed [COEF_W-1:0]          coef [9],
  output logic                              busy
);

  localparam int SHIFT = erv_pkg::TRIG_FRAC - COEF_FRAC_BITS;
  localparam logic [33:0] HALF = (34'd1 << SHIFT) >> 1;
  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;

  localparam logic [3:0] P_SASB   = 4'd0;
  localparam logic [3:0] P_CASB   = 4'd1;
  localparam logic [3:0] P_CBCG   = 4'd2;
  localparam logic [3:0] P_CASG   = 4'd3;
  localparam logic [3:0] P_SASG   = 4'd4;
  localparam logic [3:0] P_CBSG   = 4'd5;
  localparam logic [3:0] P_CACG   = 4'd6;
  localparam logic [3:0] P_SACG   = 4'd7;
  localparam logic [3:0] P_SACB   = 4'd8;
  localparam logic [3:0] P_CACB   = 4'd9;
  localparam logic [3:0] P_SASBCG = 4'd10;
  localparam logic [3:0] P_CASBCG = 4'd11;
  localparam logic [3:0] P_SASBSG = 4'd12;
  localparam logic [3:0] P_CASBSG = 4'd13;

  localparam int T_SA = 0;
  localparam int T_CA = 1;
  localparam int T_SB = 2;
  localparam int T_CB = 3;
  localparam int T_SG = 4;
  localparam int T_CG = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FOLD,
    ST_TRIG,
    ST_MUL,
    ST_DRAIN,
    ST_SUM,
    ST_ROUND
  } state_t;

  state_t state;
  logic [erv_pkg::ANGLE_W-1:0] angle_x;
  logic [erv_pkg::ANGLE_W-1:0] angle_y;
  logic [erv_pkg::ANGLE_W-1:0] angle_z;
  logic [erv_pkg::ANGLE_W-1:0] angle_sel [3];

  logic [erv_pkg::SIN_IDX_W-1:0] fold_idx [6];
  logic                          fold_neg [6];
  logic [erv_pkg::SIN_IDX_W-1:0] fold_idx_next [6];
  logic                          fold_neg_next [6];
  erv_pkg::trig_t                trig [6];
  erv_pkg::trig_t                trig_next [6];

  logic [3:0]                    step;
  erv_pkg::trig_t                op_a;
  erv_pkg::trig_t                op_b;
  logic [erv_pkg::TRIG_FRAC:0]   mag_a;
  logic [erv_pkg::TRIG_FRAC:0]   mag_b;
  logic                          mul_vld;
  logic [3:0]                    mul_idx;
  logic                          mul_neg;
  logic [61:0]                   mul_mag;
  logic [61:0]                   mul_rnd;
  erv_pkg::trig_t                mul_res;
  erv_pkg::trig_t                prod [14];

  logic signed [32:0]            m [9];
  logic signed [32:0]            m_next [9];
  logic signed [COEF_W-1:0]      coef_next [9];
  logic                          cfg_hit;

  assign angle_sel[0] = angle_x;
  assign angle_sel[1] = angle_y;
  assign angle_sel[2] = angle_z;
  assign busy = (state != ST_IDLE);
  assign cfg_hit = cfg_we && (cfg_index == erv_pkg::CFG_ANGLE_X ||
                              cfg_index == erv_pkg::CFG_ANGLE_Y ||
                              cfg_index == erv_pkg::CFG_ANGLE_Z);

  // Reduce each angle modulo 360, take cosine as sine of the angle plus 90,
  // and fold into the first quadrant of the table.
  always_comb begin
    logic [9:0] red;
    logic [9:0] ph;
    for (int j = 0; j < 6; j++) begin
      red = {1'b0, angle_sel[j >> 1]};
      if (red >= 10'd360) begin
        red = red - 10'd360;
      end
      ph = red;
      if (j % 2 == 1) begin
        ph = red + 10'd90;
        if (ph >= 10'd360) begin
          ph = ph - 10'd360;
        end
      end
      if (ph <= 10'd90) begin
        fold_idx_next[j] = ph[erv_pkg::SIN_IDX_W-1:0];
        fold_neg_next[j] = 1'b0;
      end else if (ph <= 10'd180) begin
        fold_idx_next[j] = 7'(10'd180 - ph);
        fold_neg_next[j] = 1'b0;
      end else if (ph <= 10'd270) begin
        fold_idx_next[j] = 7'(ph - 10'd180);
        fold_neg_next[j] = 1'b1;
      end else begin
        fold_idx_next[j] = 7'(10'd360 - ph);
        fold_neg_next[j] = 1'b1;
      end
    end
  end

  always_comb begin
    erv_pkg::trig_t v;
    for (int j = 0; j < 6; j++) begin
      v = erv_pkg::trig_t'({1'b0, erv_pkg::SIN_TABLE[fold_idx[j]]});
      trig_next[j] = fold_neg[j] ? -v : v;
    end
  end

  always_comb begin
    case (step)
      P_SASB:   begin op_a = trig[T_SA];     op_b = trig[T_SB]; end
      P_CASB:   begin op_a = trig[T_CA];     op_b = trig[T_SB]; end
      P_CBCG:   begin op_a = trig[T_CB];     op_b = trig[T_CG]; end
      P_CASG:   begin op_a = trig[T_CA];     op_b = trig[T_SG]; end
      P_SASG:   begin op_a = trig[T_SA];     op_b = trig[T_SG]; end
      P_CBSG:   begin op_a = trig[T_CB];     op_b = trig[T_SG]; end
      P_CACG:   begin op_a = trig[T_CA];     op_b = trig[T_CG]; end
      P_SACG:   begin op_a = trig[T_SA];     op_b = trig[T_CG]; end
      P_SACB:   begin op_a = trig[T_SA];     op_b = trig[T_CB]; end
      P_CACB:   begin op_a = trig[T_CA];     op_b = trig[T_CB]; end
      P_SASBCG: begin op_a = prod[P_SASB];   op_b = trig[T_CG]; end
      P_CASBCG: begin op_a = prod[P_CASB];   op_b = trig[T_CG]; end
      P_SASBSG: begin op_a = prod[P_SASB];   op_b = trig[T_SG]; end
      P_CASBSG: begin op_a = prod[P_CASB];   op_b = trig[T_SG]; end
      default:  begin op_a = '0;             op_b = '0;         end
    endcase
    mag_a = op_a[erv_pkg::TRIG_W-1] ? 31'(-op_a) : op_a[erv_pkg::TRIG_FRAC:0];
    mag_b = op_b[erv_pkg::TRIG_W-1] ? 31'(-op_b) : op_b[erv_pkg::TRIG_FRAC:0];
    mul_rnd = (mul_mag + (62'd1 << 29)) >> erv_pkg::TRIG_FRAC;
    mul_res = mul_neg ? -erv_pkg::trig_t'(mul_rnd) : erv_pkg::trig_t'(mul_rnd);
  end

  always_comb begin
    m_next[0] = 33'(prod[P_CBCG]);
    m_next[1] = 33'(prod[P_SASBCG]) - 33'(prod[P_CASG]);
    m_next[2] = 33'(prod[P_CASBCG]) + 33'(prod[P_SASG]);
    m_next[3] = 33'(prod[P_CBSG]);
    m_next[4] = 33'(prod[P_SASBSG]) + 33'(prod[P_CACG]);
    m_next[5] = 33'(prod[P_CASBSG]) - 33'(prod[P_SACG]);
    m_next[6] = -33'(trig[T_SB]);
    m_next[7] = 33'(prod[P_SACB]);
    m_next[8] = 33'(prod[P_CACB]);
  end

  // Round each Q30 entry half away from zero to the coefficient format.
  always_comb begin
    logic [33:0] mag;
    logic [33:0] rmag;
    for (int i = 0; i < 9; i++) begin
      mag = m[i][32] ? 34'(-m[i]) : 34'(m[i]);
      rmag = (mag + HALF) >> SHIFT;
      coef_next[i] = m[i][32] ? -COEF_W'(rmag) : COEF_W'(rmag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      angle_x <= '0;
      angle_y <= '0;
      angle_z <= '0;
      step <= '0;
      mul_vld <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        coef[i] <= (i == 0 || i == 4 || i == 8) ? COEF_ONE : '0;
      end
    end else begin
      mul_vld <= (state == ST_MUL);
      mul_idx <= step;
      mul_neg <= op_a[erv_pkg::TRIG_W-1] ^ op_b[erv_pkg::TRIG_W-1];
      mul_mag <= 62'(mag_a) * 62'(mag_b);
      if (mul_vld) begin
        prod[mul_idx] <= mul_res;
      end
      case (state)
        ST_IDLE: begin
          state <= ST_IDLE;
        end
        ST_FOLD: begin
          fold_idx <= fold_idx_next;
          fold_neg <= fold_neg_next;
          state <= ST_TRIG;
        end
        ST_TRIG: begin
          trig <= trig_next;
          step <= P_SASB;
          state <= ST_MUL;
        end
        ST_MUL: begin
          step <= step + 4'd1;
          if (step == P_CASBSG) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!mul_vld) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          m <= m_next;
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          coef <= coef_next;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cfg_hit) begin
        case (cfg_index)
          erv_pkg::CFG_ANGLE_X: angle_x <= cfg_data;
          erv_pkg::CFG_ANGLE_Y: angle_y <= cfg_data;
          default:              angle_z <= cfg_data;
        endcase
        state <= ST_FOLD;
      end
    end
  end

`ifndef SYNTHESIS
  a_write_starts_rebuild: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> busy)
    else $error("angle write did not start a matrix rebuild");

  a_product_from_issue: assert property (@(posedge clk) disable iff (rst)
    mul_vld |-> $past(state) == ST_MUL)
    else $error("product written without a multiply issue");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !mul_vld)
    else $error("multiplier still busy after the matrix was released");
`endif

endmodule

`default_nettype wire

/* sv/erv_datapath.sv */
// Four-stage vertex pipeline: partial products, product merge, row sums, round and saturate.
`default_nettype none

module erv_datapath #(
  parameter int COORD_BITS = 24,
  parameter int COEF_FRAC_BITS = 16,
  localparam int COEF_W = COEF_FRAC_BITS + 2
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire  signed [COEF_W-1:0]     coef [9],
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [COORD_BITS-1:0]        in_coord [3],
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [COORD_BITS-1:0]        out_coord [3]
);

  localparam int LO_W = COORD_BITS / 2;
  localparam int HI_W = COORD_BITS - LO_W;
  localparam int PL_W = COEF_W + LO_W + 1;
  localparam int PH_W = COEF_W + HI_W;
  localparam int PW = COEF_W + COORD_BITS;
  localparam int AW = PW + 2;
  localparam logic signed [AW-1:0] ROUND_HALF = AW'(1) << (COEF_FRAC_BITS - 1);
  localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
  localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};

  logic v1;
  logic v2;
  logic v3;
  logic v4;
  logic r1;
  logic r2;
  logic r3;
  logic r4;

  logic signed [PL_W-1:0] pl1 [9];
  logic signed [PH_W-1:0] ph1 [9];
  logic signed [PL_W-1:0] pl1_next [9];
  logic signed [PH_W-1:0] ph1_next [9];
  logic signed [PW-1:0]   prod2 [9];
  logic signed [PW-1:0]   prod2_next [9];
  logic signed [AW-1:0]   acc3 [3];
  logic signed [AW-1:0]   acc3_next [3];
  logic [COORD_BITS-1:0]  sat_next [3];

  assign r4 = !v4 || out_ready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;
  assign out_valid = v4;

  always_comb begin
    logic signed [LO_W:0]   lo;
    logic signed [HI_W-1:0] hi;
    for (int i = 0; i < 9; i++) begin
      lo = $signed({1'b0, in_coord[i % 3][LO_W-1:0]});
      hi = $signed(in_coord[i % 3][COORD_BITS-1:LO_W]);
      pl1_next[i] = PL_W'(coef[i]) * PL_W'(lo);
      ph1_next[i] = PH_W'(coef[i]) * PH_W'(hi);
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      prod2_next[i] = (PW'(ph1[i]) <<< LO_W) + PW'(pl1[i]);
    end
    for (int r = 0; r < 3; r++) begin
      acc3_next[r] = AW'(prod2[3 * r]) + AW'(prod2[3 * r + 1]) + AW'(prod2[3 * r + 2])
                     + ROUND_HALF;
    end
  end

  // The shifted sum fits when every bit above the result's sign bit matches it.
  always_comb begin
    logic [AW-COEF_FRAC_BITS-COORD_BITS:0] top;
    for (int r = 0; r < 3; r++) begin
      top = acc3[r][AW-1:COEF_FRAC_BITS+COORD_BITS-1];
      if ((&top) || !(|top)) begin
        sat_next[r] = acc3[r][COEF_FRAC_BITS+COORD_BITS-1:COEF_FRAC_BITS];
      end else begin
        sat_next[r] = acc3[r][AW-1] ? COORD_MIN : COORD_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= in_valid;
        pl1 <= pl1_next;
        ph1 <= ph1_next;
      end
      if (r2) begin
        v2 <= v1;
        prod2 <= prod2_next;
      end
      if (r3) begin
        v3 <= v2;
        acc3 <= acc3_next;
      end
      if (r4) begin
        v4 <= v3;
        out_coord <= sat_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("accepted request did not enter the first stage");

  a_stage_advances: assert property (@(posedge clk) disable iff (rst)
    v1 && r2 |=> v2)
    else $error("request lost between the first and second stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    v3 && !r4 |=> v3 && $stable(acc3[0]))
    else $error("stalled row sum was overwritten");
`endif

endmodule

`default_nettype wire

/* sv/euler_rotate_vertex_top.sv */
// Top level of the Euler-angle vertex rotator: stream ports, angle registers, matrix and pipeline.
// One vertex per cycle sustained while no angle write is rebuilding the matrix and the output does not stall.
// An angle write rebuilds the matrix on one shared 31x31 multiplier, during
// which s_axis_tready is low; an output stall backs up through the four pipeline registers.
// Reset: all angles read 0, the matrix is the identity and the pipeline is empty.
`default_nettype none

module euler_rotate_vertex_top #(
  parameter int COORD_BITS = 24,
  parameter int COEF_FRAC_BITS = 16,
  localparam int DATA_W = ((3 * COORD_BITS + 7) / 8) * 8
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire  [DATA_W-1:0]                s_axis_tdata,  // x_in, y_in, z_in, zero pad
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [DATA_W-1:0]                m_axis_tdata,  // x_out, y_out, z_out, zero pad
  input  wire                              cfg_we,
  input  wire  [erv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [erv_pkg::ANGLE_W-1:0]      cfg_data
);

  localparam int COEF_W = COEF_FRAC_BITS + 2;

  logic signed [COEF_W-1:0]  coef [9];
  logic                      busy;
  logic                      pipe_ready;
  logic [COORD_BITS-1:0]     in_coord [3];
  logic [COORD_BITS-1:0]     out_coord [3];

  assign in_coord[0] = s_axis_tdata[COORD_BITS-1:0];
  assign in_coord[1] = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_coord[2] = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign s_axis_tready = pipe_ready && !busy;
  assign m_axis_tdata = DATA_W'({out_coord[2], out_coord[1], out_coord[0]});

  erv_matrix #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_matrix (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .coef     (coef),
    .busy     (busy)
  );

  erv_datapath #(
    .COORD_BITS    (COORD_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .coef     (coef),
    .in_valid (s_axis_tvalid && !busy),
    .in_ready (pipe_ready),
    .in_coord (in_coord),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_coord(out_coord)
  );

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the Euler-angle vertex rotator: angle writes and streamed vertices.
`timescale 1ns / 1ps

module testbench;

  localparam int COORD_W = 24;
  localparam int COEF_FRAC = 16;
  localparam int Q30 = 30;
  localparam longint unsigned PI_SCALED = 64'd3373259426;
  localparam logic [erv_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic signed [COORD_W-1:0] COORD_HI = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] COORD_LO = 24'sh800000;
  localparam int BACKLOG_LEN = 400;
  localparam int QUIET_LIMIT = 3000;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vertex_t;

  typedef enum logic [2:0] {
    FLOW_FREE,
    FLOW_SEND_GAPS,
    FLOW_RECV_STALLS,
    FLOW_BOTH_GAPS,
    FLOW_BACKLOG
  } flow_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  vertex_t s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  vertex_t m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [erv_pkg::CFG_IDX_W-1:0] cfg_index = erv_pkg::CFG_ANGLE_X;
  logic [erv_pkg::ANGLE_W-1:0] cfg_data = '0;

  flow_t flow = FLOW_FREE;
  vertex_t vertices_to_send[$];
  vertex_t expected_rotated[$];
  vertex_t seen;
  vertex_t wanted;
  int failures = 0;
  int backlog_cycles = 0;
  int quiet_cycles = 0;

  logic [erv_pkg::ANGLE_W-1:0] ax_deg = '0;
  logic [erv_pkg::ANGLE_W-1:0] ay_deg = '0;
  logic [erv_pkg::ANGLE_W-1:0] az_deg = '0;
  longint rot_coef[9];

  euler_rotate_vertex_top uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Sign-magnitude right shift that rounds half away from zero.
  function automatic longint round_away(input longint v, input int s);
    longint unsigned mag;
    mag = (v < 0) ? longint'(-v) : v;
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint mul_trig(input longint a, input longint b);
    return round_away(a * b, Q30);
  endfunction

  function automatic longint quarter_sine(input int unsigned d);
    longint unsigned x, x2, term, sum;
    x = (longint'(d) * PI_SCALED + 64'd90) / 64'd180;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum = x;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2 + (64'd1 << 29)) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum > (64'd1 << Q30)) begin
      sum = 64'd1 << Q30;
    end
    return longint'(sum);
  endfunction

  function automatic longint sine_deg(input int unsigned a);
    if (a <= 90) return quarter_sine(a);
    if (a <= 180) return quarter_sine(180 - a);
    if (a <= 270) return -quarter_sine(a - 180);
    return -quarter_sine(360 - a);
  endfunction

  function automatic void load_rotation();
    int unsigned ax, ay, az;
    longint sa, ca, sb, cb, sg, cg, sasb, casb;
    longint m[9];
    ax = ax_deg % 360;
    ay = ay_deg % 360;
    az = az_deg % 360;
    sa = sine_deg(ax);
    ca = sine_deg((ax + 90) % 360);
    sb = sine_deg(ay);
    cb = sine_deg((ay + 90) % 360);
    sg = sine_deg(az);
    cg = sine_deg((az + 90) % 360);
    sasb = mul_trig(sa, sb);
    casb = mul_trig(ca, sb);
    m[0] = mul_trig(cb, cg);
    m[1] = mul_trig(sasb, cg) - mul_trig(ca, sg);
    m[2] = mul_trig(casb, cg) + mul_trig(sa, sg);
    m[3] = mul_trig(cb, sg);
    m[4] = mul_trig(sasb, sg) + mul_trig(ca, cg);
    m[5] = mul_trig(casb, sg) - mul_trig(sa, cg);
    m[6] = -sb;
    m[7] = mul_trig(sa, cb);
    m[8] = mul_trig(ca, cb);
    for (int i = 0; i < 9; i++) begin
      rot_coef[i] = round_away(m[i], Q30 - COEF_FRAC);
    end
  endfunction

  function automatic vertex_t rotate_vertex(input vertex_t v);
    longint comp[3];
    longint acc;
    logic signed [COORD_W-1:0] res[3];
    vertex_t r;
    comp[0] = longint'(v.x);
    comp[1] = longint'(v.y);
    comp[2] = longint'(v.z);
    for (int row = 0; row < 3; row++) begin
      acc = rot_coef[3 * row] * comp[0] + rot_coef[3 * row + 1] * comp[1]
          + rot_coef[3 * row + 2] * comp[2] + (64'sd1 <<< (COEF_FRAC - 1));
      acc = acc >>> COEF_FRAC;
      if (acc > longint'(COORD_HI)) begin
        acc = longint'(COORD_HI);
      end else if (acc < longint'(COORD_LO)) begin
        acc = longint'(COORD_LO);
      end
      res[row] = acc[COORD_W-1:0];
    end
    r.x = res[0];
    r.y = res[1];
    r.z = res[2];
    return r;
  endfunction

  function automatic vertex_t vtx(input logic signed [COORD_W-1:0] x,
                                  input logic signed [COORD_W-1:0] y,
                                  input logic signed [COORD_W-1:0] z);
    vertex_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    return v;
  endfunction

  function automatic logic signed [COORD_W-1:0] random_coord();
    case ($urandom_range(9))
      0: return COORD_HI;
      1: return COORD_LO;
      2: return '0;
      3, 4, 5: return 24'($urandom_range(16383)) - 24'd8192;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [erv_pkg::ANGLE_W-1:0] pick_angle();
    case ($urandom_range(9))
      0: return 9'd0;
      1: return 9'd359;
      2: return 9'd360;
      3: return 9'd511;
      4: return 9'd90;
      default: return 9'($urandom_range(511));
    endcase
  endfunction

  function automatic bit sender_pauses();
    case (flow)
      FLOW_SEND_GAPS: return $urandom_range(99) < 70;
      FLOW_BOTH_GAPS: return $urandom_range(99) < 12;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (flow)
      FLOW_RECV_STALLS: return $urandom_range(99) < 70;
      FLOW_BOTH_GAPS: return $urandom_range(99) < 12;
      default: return 1'b0;
    endcase
  endfunction

  // Source side: hold a request until it is taken, predict the rotation on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_rotated.push_back(rotate_vertex(s_axis_tdata));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (vertices_to_send.size() != 0 && !sender_pauses()) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= vertices_to_send.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink side: random stalls, plus one long hold-off that backs the pipeline up.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (flow == FLOW_BACKLOG && backlog_cycles < BACKLOG_LEN) begin
      m_axis_tready <= 1'b0;
      backlog_cycles <= backlog_cycles + 1;
    end else begin
      m_axis_tready <= !receiver_stalls();
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen = m_axis_tdata;
      if (expected_rotated.size() == 0) begin
        $error("unexpected result x=%0d y=%0d z=%0d", seen.x, seen.y, seen.z);
        failures++;
      end else begin
        wanted = expected_rotated.pop_front();
        if (seen.x !== wanted.x) begin
          $error("x_out mismatch: expected %0d, got %0d", wanted.x, seen.x);
          failures++;
        end
        if (seen.y !== wanted.y) begin
          $error("y_out mismatch: expected %0d, got %0d", wanted.y, seen.y);
          failures++;
        end
        if (seen.z !== wanted.z) begin
          $error("z_out mismatch: expected %0d, got %0d", wanted.z, seen.z);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready)
        || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (vertices_to_send.size() != 0 || s_axis_tvalid || expected_rotated.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // The matrix rebuild holds s_axis_tready low, so the next write waits for it to rise.
  task automatic write_angle(input logic [erv_pkg::CFG_IDX_W-1:0] idx,
                             input logic [erv_pkg::ANGLE_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      erv_pkg::CFG_ANGLE_X: ax_deg = val;
      erv_pkg::CFG_ANGLE_Y: ay_deg = val;
      erv_pkg::CFG_ANGLE_Z: az_deg = val;
      default: ;
    endcase
    if (idx != CFG_SPARE) begin
      load_rotation();
    end
    @(posedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
    end
  endtask

  task automatic random_phase(input flow_t mode, input int count);
    if ($urandom_range(2) != 0) write_angle(erv_pkg::CFG_ANGLE_X, pick_angle());
    if ($urandom_range(2) != 0) write_angle(erv_pkg::CFG_ANGLE_Y, pick_angle());
    if ($urandom_range(2) != 0) write_angle(erv_pkg::CFG_ANGLE_Z, pick_angle());
    if ($urandom_range(4) == 0) write_angle(CFG_SPARE, pick_angle());
    flow = mode;
    for (int i = 0; i < count; i++) begin
      vertices_to_send.push_back(vtx(random_coord(), random_coord(), random_coord()));
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < 9; i++) begin
      rot_coef[i] = (i % 4 == 0) ? (64'sd1 <<< COEF_FRAC) : 64'sd0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Identity matrix after reset, field extremes and alternating bit patterns.
    vertices_to_send.push_back(vtx('0, '0, '0));
    vertices_to_send.push_back(vtx(COORD_HI, COORD_LO, -24'sd1));
    vertices_to_send.push_back(vtx(COORD_LO, COORD_HI, 24'sd1));
    vertices_to_send.push_back(vtx(24'sh555555, 24'shAAAAAA, COORD_HI));
    vertices_to_send.push_back(vtx(24'shAAAAAA, 24'sh555555, COORD_LO));
    wait_drained();

    // A 45 degree turn about z pushes full-scale vertices into saturation both ways.
    write_angle(erv_pkg::CFG_ANGLE_Z, 9'd45);
    vertices_to_send.push_back(vtx(COORD_HI, COORD_HI, '0));
    vertices_to_send.push_back(vtx(COORD_LO, COORD_LO, '0));
    vertices_to_send.push_back(vtx(COORD_HI, COORD_LO, COORD_HI));
    vertices_to_send.push_back(vtx(24'sd256, -24'sd256, 24'sd512));
    wait_drained();

    // A write to the unused index must leave the matrix alone.
    write_angle(CFG_SPARE, 9'd511);
    vertices_to_send.push_back(vtx(COORD_HI, '0, '0));
    wait_drained();

    // Angles of 360 and above wrap around.
    write_angle(erv_pkg::CFG_ANGLE_X, 9'd511);
    write_angle(erv_pkg::CFG_ANGLE_Y, 9'd360);
    write_angle(erv_pkg::CFG_ANGLE_Z, 9'd359);
    vertices_to_send.push_back(vtx(COORD_HI, COORD_LO, COORD_HI));
    vertices_to_send.push_back(vtx(24'sd1, 24'sd2, 24'sd3));
    wait_drained();

    write_angle(erv_pkg::CFG_ANGLE_X, 9'd90);
    write_angle(erv_pkg::CFG_ANGLE_Y, 9'd180);
    write_angle(erv_pkg::CFG_ANGLE_Z, 9'd270);
    vertices_to_send.push_back(vtx(COORD_HI, 24'sd1, COORD_LO));
    vertices_to_send.push_back(vtx(-24'sd5, 24'sd7, -24'sd9));
    wait_drained();

    random_phase(FLOW_BACKLOG, 60);
    for (int p = 0; p < 15; p++) begin
      case (p % 4)
        0: random_phase(FLOW_FREE, 125);
        1: random_phase(FLOW_SEND_GAPS, 125);
        2: random_phase(FLOW_RECV_STALLS, 125);
        default: random_phase(FLOW_BOTH_GAPS, 125);
      endcase
    end

    repeat (10) @(posedge clk);
    if (failures == 0 && expected_rotated.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
